FILE: hw/rtl/pmps_pkg.sv
// Package for the phased message poll scheduler: phase codes, microcode word
// layout, micro-addresses and the control store. No dependencies.
package pmps_pkg;

  localparam int unsigned LIST_DEPTH = 8;
  localparam int unsigned STEP_GUARD = 12;
  localparam logic [31:0] IDLE_WAIT_MS = 32'd1000;

  localparam int unsigned GUARD_W = $clog2(STEP_GUARD + 2);
  localparam int unsigned UPC_W   = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_INIT_LIST    = 3'd0;
  localparam logic [2:0] REG_FAST_LIST    = 3'd1;
  localparam logic [2:0] REG_SLOW_LIST    = 3'd2;
  localparam logic [2:0] REG_LIST_LENGTHS = 3'd3;
  localparam logic [2:0] REG_TX_GAP_MS    = 3'd4;
  localparam logic [2:0] REG_SLOW_GAP_MS  = 3'd5;
  localparam logic [2:0] REG_FAST_ROUNDS  = 3'd6;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_FAST = 2'd1,
    PH_GAP  = 2'd2,
    PH_SLOW = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_GUARD_INC,
    OP_ENTER_FAST,
    OP_SEND,
    OP_ROUND_NEXT,
    OP_GO_GAP,
    OP_IDLE_WAIT,
    OP_GO_SLOW,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    NX_SEQ,
    NX_JUMP,
    NX_BRANCH,
    NX_DISPATCH
  } nxt_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_NOT_DUE,
    C_IDX_GE_N,
    C_IDX_LT_N,
    C_LIST_EMPTY,
    C_RC_LT_ROUNDS
  } cond_e;

  typedef enum logic [1:0] {
    LS_INIT,
    LS_FAST,
    LS_SLOW
  } list_sel_e;

  typedef struct packed {
    op_e              op;
    nxt_e             nxt;
    cond_e            cond;
    list_sel_e        sel;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Micro-addresses
  localparam logic [UPC_W-1:0] UA_CHK      = 5'd0;
  localparam logic [UPC_W-1:0] UA_DSP      = 5'd1;
  localparam logic [UPC_W-1:0] UA_INIT     = 5'd2;
  localparam logic [UPC_W-1:0] UA_INIT_TX  = 5'd3;
  localparam logic [UPC_W-1:0] UA_EF       = 5'd4;
  localparam logic [UPC_W-1:0] UA_FAST     = 5'd5;
  localparam logic [UPC_W-1:0] UA_FAST_IX  = 5'd6;
  localparam logic [UPC_W-1:0] UA_FAST_RND = 5'd7;
  localparam logic [UPC_W-1:0] UA_FAST_RC  = 5'd8;
  localparam logic [UPC_W-1:0] UA_FAST_END = 5'd9;
  localparam logic [UPC_W-1:0] UA_FAST_TX  = 5'd10;
  localparam logic [UPC_W-1:0] UA_FAST_NIL = 5'd11;
  localparam logic [UPC_W-1:0] UA_NIL_GAP  = 5'd12;
  localparam logic [UPC_W-1:0] UA_NIL_IDLE = 5'd13;
  localparam logic [UPC_W-1:0] UA_GAP      = 5'd14;
  localparam logic [UPC_W-1:0] UA_SLOW     = 5'd15;
  localparam logic [UPC_W-1:0] UA_SLOW_TX  = 5'd16;
  localparam logic [UPC_W-1:0] UA_EMIT     = 5'd17;

  function automatic ucode_t uw(op_e op, nxt_e nxt, cond_e cond, list_sel_e sel,
                                logic [UPC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.nxt    = nxt;
    w.cond   = cond;
    w.sel    = sel;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] a);
    ucode_t w;
    unique case (a)
      UA_CHK:      w = uw(OP_GUARD_INC,  NX_BRANCH,   C_NOT_DUE,      LS_INIT, UA_EMIT);
      UA_DSP:      w = uw(OP_NOP,        NX_DISPATCH, C_NONE,         LS_INIT, UA_CHK);
      UA_INIT:     w = uw(OP_NOP,        NX_BRANCH,   C_IDX_GE_N,     LS_INIT, UA_EF);
      UA_INIT_TX:  w = uw(OP_SEND,       NX_JUMP,     C_NONE,         LS_INIT, UA_EMIT);
      UA_EF:       w = uw(OP_ENTER_FAST, NX_JUMP,     C_NONE,         LS_INIT, UA_CHK);
      UA_FAST:     w = uw(OP_NOP,        NX_BRANCH,   C_LIST_EMPTY,   LS_FAST, UA_FAST_NIL);
      UA_FAST_IX:  w = uw(OP_NOP,        NX_BRANCH,   C_IDX_LT_N,     LS_FAST, UA_FAST_TX);
      UA_FAST_RND: w = uw(OP_ROUND_NEXT, NX_SEQ,      C_NONE,         LS_FAST, UA_CHK);
      UA_FAST_RC:  w = uw(OP_NOP,        NX_BRANCH,   C_RC_LT_ROUNDS, LS_FAST, UA_FAST_TX);
      UA_FAST_END: w = uw(OP_GO_GAP,     NX_JUMP,     C_NONE,         LS_FAST, UA_EMIT);
      UA_FAST_TX:  w = uw(OP_SEND,       NX_JUMP,     C_NONE,         LS_FAST, UA_EMIT);
      UA_FAST_NIL: w = uw(OP_NOP,        NX_BRANCH,   C_LIST_EMPTY,   LS_SLOW, UA_NIL_IDLE);
      UA_NIL_GAP:  w = uw(OP_GO_GAP,     NX_JUMP,     C_NONE,         LS_FAST, UA_EMIT);
      UA_NIL_IDLE: w = uw(OP_IDLE_WAIT,  NX_JUMP,     C_NONE,         LS_FAST, UA_EMIT);
      UA_GAP:      w = uw(OP_GO_SLOW,    NX_JUMP,     C_NONE,         LS_SLOW, UA_CHK);
      UA_SLOW:     w = uw(OP_NOP,        NX_BRANCH,   C_IDX_GE_N,     LS_SLOW, UA_EF);
      UA_SLOW_TX:  w = uw(OP_SEND,       NX_JUMP,     C_NONE,         LS_SLOW, UA_EMIT);
      UA_EMIT:     w = uw(OP_EMIT,       NX_JUMP,     C_NONE,         LS_INIT, UA_EMIT);
      default:     w = uw(OP_NOP,        NX_JUMP,     C_NONE,         LS_INIT, UA_EMIT);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch_addr(phase_e ph);
    logic [UPC_W-1:0] a;
    unique case (ph)
      PH_INIT: a = UA_INIT;
      PH_FAST: a = UA_FAST;
      PH_GAP:  a = UA_GAP;
      PH_SLOW: a = UA_SLOW;
      default: a = UA_EMIT;
    endcase
    return a;
  endfunction

  // Entry count, saturated to the list depth
  function automatic logic [3:0] count_sat(logic [3:0] raw);
    logic [3:0] lim;
    lim = 4'(LIST_DEPTH);
    return (raw > lim) ? lim : raw;
  endfunction

endpackage

FILE: hw/rtl/phased_message_poll_scheduler.sv
// Phased message poll scheduler top level: microcoded sequencer and datapath.
// Depends on pmps_pkg (control store, phase codes, constants).
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one poll item: now_ms_i,
//   the free-running millisecond time. Output channel (out_valid_o /
//   out_ready_i) returns exactly one item per poll: send_o, entry_id_o and
//   phase_now_o (phase after the poll). A poll that is not yet due returns
//   send_o = 0 and leaves the schedule untouched.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i),
//   taken at any edge with cfg_we_i high; write only while the block is idle.
// Sequencing
//   One item at a time. A poll that is not due goes from the due check to the
//   emit step; a send passes dispatch and the list checks, a fast send that
//   wraps a round also the round steps, and the longest chain runs from the gap
//   through an empty slow list to a fast send. The microprogram runs one control
//   word per cycle unless held on emit; each pass re-checks the due time and
//   the step guard. in_ready_o rises again in the cycle the result is loaded
//   into the output register, so a new poll is taken while that result waits.
// Reset
//   Clears the schedule (start-up phase, due time 0) and loads the register
//   defaults. Nothing to sweep; the first poll may follow at once.
// Stall
//   If the output register still holds an untaken item, hold the sequencer
//   on its emit step until the receiver takes it.
module phased_message_poll_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_o,
  output logic [7:0]  entry_id_o,
  output logic [1:0]  phase_now_o
);
  import pmps_pkg::*;

  localparam logic [GUARD_W-1:0] GUARD_LIM = GUARD_W'(STEP_GUARD);

  // Configuration registers
  logic [63:0] init_list_q, fast_list_q, slow_list_q;
  logic [11:0] list_lengths_q;
  logic [15:0] tx_gap_ms_q, slow_gap_ms_q;
  logic [7:0]  fast_rounds_q;

  // Schedule state
  phase_e      phase_q, phase_d;
  logic [3:0]  entry_index_q, entry_index_d;
  logic [7:0]  round_count_q, round_count_d;
  logic [31:0] due_time_q, due_time_d;

  // Per-poll working registers
  logic               busy_q, busy_d;
  logic [UPC_W-1:0]   upc_q, upc_d;
  logic [GUARD_W-1:0] guard_q, guard_d;
  logic [31:0]        now_q;
  logic               send_q, send_d;
  logic [7:0]         id_q, id_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic       out_send_q;
  logic [7:0] out_id_q;
  logic [1:0] out_phase_q;

  ucode_t      uw_c;
  logic [3:0]  sel_count;
  logic [63:0] sel_list;
  logic [7:0]  sel_entry;
  logic [31:0] diff;
  logic        not_due;
  logic        cond_true;
  logic        emit_go;
  logic        in_acc;
  logic [31:0] due_addend;
  logic [31:0] due_sum;

  assign uw_c        = ucode_rom(upc_q);
  assign in_ready_o  = ~busy_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign send_o      = out_send_q;
  assign entry_id_o  = out_id_q;
  assign phase_now_o = out_phase_q;

  // List selected by the current control word
  always_comb begin
    unique case (uw_c.sel)
      LS_INIT: begin
        sel_count = count_sat(list_lengths_q[3:0]);
        sel_list  = init_list_q;
      end
      LS_FAST: begin
        sel_count = count_sat(list_lengths_q[7:4]);
        sel_list  = fast_list_q;
      end
      LS_SLOW: begin
        sel_count = count_sat(list_lengths_q[11:8]);
        sel_list  = slow_list_q;
      end
      default: begin
        sel_count = '0;
        sel_list  = '0;
      end
    endcase
  end

  assign sel_entry = sel_list[8*entry_index_q[2:0] +: 8];

  // Wrap-aware due check: negative difference, or a spent step guard, means not yet due
  assign diff    = now_q - due_time_q;
  assign not_due = diff[31] | (guard_q >= GUARD_LIM);

  always_comb begin
    unique case (uw_c.cond)
      C_NOT_DUE:      cond_true = not_due;
      C_IDX_GE_N:     cond_true = entry_index_q >= sel_count;
      C_IDX_LT_N:     cond_true = entry_index_q < sel_count;
      C_LIST_EMPTY:   cond_true = sel_count == 4'd0;
      C_RC_LT_ROUNDS: cond_true = round_count_q < fast_rounds_q;
      default:        cond_true = 1'b0;
    endcase
  end

  // Emit only when the output register is free or being drained
  assign emit_go = ~out_valid_q | out_ready_i;

  // Next micro-address
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (in_acc) begin
      busy_d = 1'b1;
      upc_d  = UA_CHK;
    end else if (busy_q) begin
      if (uw_c.op == OP_EMIT) begin
        if (emit_go) begin
          busy_d = 1'b0;
        end
      end else begin
        unique case (uw_c.nxt)
          NX_SEQ:      upc_d = upc_q + 1'b1;
          NX_JUMP:     upc_d = uw_c.target;
          NX_BRANCH:   upc_d = cond_true ? uw_c.target : upc_q + 1'b1;
          NX_DISPATCH: upc_d = dispatch_addr(phase_q);
          default:     upc_d = UA_EMIT;
        endcase
      end
    end
  end

  // One adder serves every due-time update
  always_comb begin
    unique case (uw_c.op)
      OP_SEND:      due_addend = {16'd0, tx_gap_ms_q};
      OP_GO_GAP:    due_addend = {16'd0, slow_gap_ms_q};
      OP_IDLE_WAIT: due_addend = IDLE_WAIT_MS;
      default:      due_addend = '0;
    endcase
  end
  assign due_sum = now_q + due_addend;

  // Datapath actions of the current control word
  always_comb begin
    phase_d       = phase_q;
    entry_index_d = entry_index_q;
    round_count_d = round_count_q;
    due_time_d    = due_time_q;
    guard_d       = guard_q;
    send_d        = send_q;
    id_d          = id_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    if (in_acc) begin
      guard_d = '0;
      send_d  = 1'b0;
      id_d    = '0;
    end else if (busy_q) begin
      unique case (uw_c.op)
        OP_NOP: ;
        OP_GUARD_INC: begin
          if (!not_due) guard_d = guard_q + 1'b1;
        end
        OP_ENTER_FAST: begin
          phase_d       = PH_FAST;
          entry_index_d = '0;
          round_count_d = '0;
          due_time_d    = due_sum;
        end
        OP_SEND: begin
          send_d        = 1'b1;
          id_d          = sel_entry;
          entry_index_d = entry_index_q + 1'b1;
          due_time_d    = due_sum;
        end
        OP_ROUND_NEXT: begin
          entry_index_d = '0;
          round_count_d = round_count_q + 1'b1;
        end
        OP_GO_GAP: begin
          phase_d    = PH_GAP;
          due_time_d = due_sum;
        end
        OP_IDLE_WAIT: due_time_d = due_sum;
        OP_GO_SLOW: begin
          phase_d       = PH_SLOW;
          entry_index_d = '0;
          due_time_d    = due_sum;
        end
        OP_EMIT: begin
          if (emit_go) out_valid_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_list_q    <= '0;
      fast_list_q    <= '0;
      slow_list_q    <= '0;
      list_lengths_q <= '0;
      tx_gap_ms_q    <= 16'd1;
      slow_gap_ms_q  <= 16'd10;
      fast_rounds_q  <= 8'd25;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_INIT_LIST:    init_list_q    <= cfg_wdata_i;
        REG_FAST_LIST:    fast_list_q    <= cfg_wdata_i;
        REG_SLOW_LIST:    slow_list_q    <= cfg_wdata_i;
        REG_LIST_LENGTHS: list_lengths_q <= cfg_wdata_i[11:0];
        REG_TX_GAP_MS:    tx_gap_ms_q    <= cfg_wdata_i[15:0];
        REG_SLOW_GAP_MS:  slow_gap_ms_q  <= cfg_wdata_i[15:0];
        REG_FAST_ROUNDS:  fast_rounds_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_INIT;
      entry_index_q <= '0;
      round_count_q <= '0;
      due_time_q    <= '0;
      busy_q        <= 1'b0;
      upc_q         <= UA_CHK;
      guard_q       <= '0;
      send_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      entry_index_q <= entry_index_d;
      round_count_q <= round_count_d;
      due_time_q    <= due_time_d;
      busy_q        <= busy_d;
      upc_q         <= upc_d;
      guard_q       <= guard_d;
      send_q        <= send_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    if (in_acc) now_q <= now_ms_i;
    if (busy_q && uw_c.op == OP_EMIT && emit_go) begin
      out_send_q  <= send_q;
      out_id_q    <= id_q;
      out_phase_q <= phase_q;
    end
  end

  // Assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> busy_q && upc_q == UA_CHK)
    else $error("poll accepted but sequencer not started");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> upc_q <= UA_EMIT)
    else $error("micro-address out of range");

  a_guard_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_q <= GUARD_LIM)
    else $error("step guard overrun");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_index_q <= 4'(LIST_DEPTH))
    else $error("entry index past list depth");

  a_id_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_o |-> entry_id_o == 8'd0)
    else $error("entry id set without send");

endmodule
